@@ design/checked_signed_alu_defines.svh @@
// ----------------------------------------------------------------------------
// checked signed alu assertion macros
// shared property wrappers for the pipeline checks
// ----------------------------------------------------------------------------
`ifndef CHECKED_SIGNED_ALU_DEFINES_SVH
`define CHECKED_SIGNED_ALU_DEFINES_SVH

// checked property, off while reset is high
`define CSA_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked property that also holds through reset
`define CSA_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/csa_pkg.sv @@
// ----------------------------------------------------------------------------
// csa_pkg
// widths, operation codes and pipeline stage record of the checked alu
// ----------------------------------------------------------------------------
package csa_pkg;

  localparam int W  = 32;
  // s0 raw, s1 prep, W divide steps
  localparam int NS = W + 2;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_REM = 3'd4;

  localparam logic [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};

  typedef struct packed {
    logic [2:0]     cmd;
    logic           a_neg;
    logic           b_neg;
    logic           err;
    logic [W-1:0]   sum;
    logic [2*W-1:0] prod;
    logic [W-1:0]   rem;
    logic [W-1:0]   quo;
    logic [W-1:0]   mb;
  } stage_t;

  // one restoring divide step
  function automatic stage_t div_step(input stage_t s);
    logic [W:0] sh;
    logic [W:0] diff;
    stage_t     o;
    o    = s;
    sh   = {s.rem, s.quo[W-1]};
    diff = sh - {1'b0, s.mb};
    if (!diff[W]) begin
      o.rem = diff[W-1:0];
      o.quo = {s.quo[W-2:0], 1'b1};
    end else begin
      o.rem = sh[W-1:0];
      o.quo = {s.quo[W-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage

@@ design/csa_req_if.sv @@
// ----------------------------------------------------------------------------
// csa_req_if
// request channel: operation code and two signed operands
// ----------------------------------------------------------------------------
interface csa_req_if;
  logic                    valid;
  logic                    ready;
  logic [2:0]              cmd;
  logic signed [csa_pkg::W-1:0] operand_a;
  logic signed [csa_pkg::W-1:0] operand_b;

  modport source (output valid, output cmd, output operand_a, output operand_b,
                  input ready);
  modport sink   (input valid, input cmd, input operand_a, input operand_b,
                  output ready);
endinterface

@@ design/csa_rsp_if.sv @@
// ----------------------------------------------------------------------------
// csa_rsp_if
// result channel: signed result and error flag
// ----------------------------------------------------------------------------
interface csa_rsp_if;
  logic                         valid;
  logic                         ready;
  logic signed [csa_pkg::W-1:0] result;
  logic                         overflow_error;

  modport source (output valid, output result, output overflow_error, input ready);
  modport sink   (input valid, input result, input overflow_error, output ready);
endinterface

@@ design/csa_stage.sv @@
// ----------------------------------------------------------------------------
// csa_stage
// one pipeline register carrying the record and doing one divide step
// ----------------------------------------------------------------------------
module csa_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  logic            in_valid,
  input  csa_pkg::stage_t in_st,
  output logic            valid,
  output csa_pkg::stage_t st
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (adv) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st <= csa_pkg::div_step(in_st);
    end
  end

endmodule

@@ design/checked_signed_alu.sv @@
// ----------------------------------------------------------------------------
// checked_signed_alu
// signed add, subtract, multiply, divide and remainder with overflow flag
// ----------------------------------------------------------------------------
// channel  dir  payload
// req      in   cmd, operand_a, operand_b
// rsp      out  result, overflow_error
//
// one request per cycle unless a stalled rsp backs the pipeline up; the depth
// is set by the restoring divider, one quotient bit per stage.
// rst is synchronous and clears all stage valid bits.
// every stage advances when it is empty or its successor advances, so bubbles
// close up and a stalled rsp holds while earlier stages keep filling.
// ----------------------------------------------------------------------------
`include "checked_signed_alu_defines.svh"

module checked_signed_alu (
  input  logic      clk,
  input  logic      rst,
  csa_req_if.sink   req,
  csa_rsp_if.source rsp
);

  localparam int W  = csa_pkg::W;
  localparam int NS = csa_pkg::NS;

  logic [NS:0]     v;
  logic [NS:0]     adv;
  csa_pkg::stage_t st [1:NS-1];

  logic [2:0]   cmd0;
  logic [W-1:0] a0;
  logic [W-1:0] b0;

  assign adv[NS] = !v[NS] || rsp.ready;
  genvar k;
  generate
    for (k = 0; k < NS; k++) begin : g_adv
      assign adv[k] = !v[k] || adv[k+1];
    end
  endgenerate

  assign req.ready = adv[0];

  // s0: raw request
  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (adv[0]) begin
      v[0] <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      cmd0 <= req.cmd;
      a0   <= req.operand_a;
      b0   <= req.operand_b;
    end
  end

  // s1 prep: magnitudes, sum, product, divide setup
  csa_pkg::stage_t prep;
  logic [W-1:0]    ma;
  logic [W-1:0]    mb;
  logic [W-1:0]    sum;
  logic            add_err;
  logic            div_err;

  always_comb begin
    ma      = a0[W-1] ? (~a0 + 1'b1) : a0;
    mb      = b0[W-1] ? (~b0 + 1'b1) : b0;
    div_err = (b0 == '0) || (a0 == csa_pkg::SMIN && b0 == '1);
    if (cmd0 == csa_pkg::OP_SUB) begin
      sum     = a0 - b0;
      add_err = (a0[W-1] ^ b0[W-1]) & (a0[W-1] ^ sum[W-1]);
    end else begin
      sum     = a0 + b0;
      add_err = ~(a0[W-1] ^ b0[W-1]) & (a0[W-1] ^ sum[W-1]);
    end
    prep.cmd   = cmd0;
    prep.a_neg = a0[W-1];
    prep.b_neg = b0[W-1];
    prep.sum   = sum;
    prep.prod  = (2*W)'(ma) * (2*W)'(mb);
    prep.rem   = '0;
    prep.quo   = ma;
    prep.mb    = mb;
    case (cmd0) inside
      csa_pkg::OP_ADD, csa_pkg::OP_SUB: prep.err = add_err;
      csa_pkg::OP_MUL:                  prep.err = 1'b0;
      csa_pkg::OP_DIV, csa_pkg::OP_REM: prep.err = div_err;
      default:                          prep.err = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v[1] <= 1'b0;
    end else if (adv[1]) begin
      v[1] <= v[0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      st[1] <= prep;
    end
  end

  generate
    for (k = 2; k < NS; k++) begin : g_div
      csa_stage u_stage (
        .clk      (clk),
        .rst      (rst),
        .adv      (adv[k]),
        .in_valid (v[k-1]),
        .in_st    (st[k-1]),
        .valid    (v[k]),
        .st       (st[k])
      );
    end
  endgenerate

  // output stage: sign fix-up and multiply range check
  csa_pkg::stage_t fin;
  logic [W-1:0]    res;
  logic            err;
  logic            neg;
  logic [W-1:0]    lo;

  always_comb begin
    fin = st[NS-1];
    neg = fin.a_neg ^ fin.b_neg;
    lo  = fin.prod[W-1:0];
    err = fin.err;
    case (fin.cmd) inside
      csa_pkg::OP_ADD, csa_pkg::OP_SUB: res = fin.sum;
      csa_pkg::OP_MUL: begin
        res = neg ? (~lo + 1'b1) : lo;
        if (fin.prod[2*W-1:W] != '0 ||
            lo > (neg ? csa_pkg::SMIN : csa_pkg::SMAX)) begin
          err = 1'b1;
        end
      end
      csa_pkg::OP_DIV: res = neg ? (~fin.quo + 1'b1) : fin.quo;
      csa_pkg::OP_REM: res = fin.a_neg ? (~fin.rem + 1'b1) : fin.rem;
      default:         res = '1;
    endcase
    if (err) begin
      res = '1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v[NS] <= 1'b0;
    end else if (adv[NS]) begin
      v[NS] <= v[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[NS]) begin
      rsp.result         <= res;
      rsp.overflow_error <= err;
    end
  end

  assign rsp.valid = v[NS];

  `CSA_ASSERT(a_err_all_ones, clk, rst, rsp.valid && rsp.overflow_error |-> rsp.result == '1, "err")
  `CSA_ASSERT(a_accept_fills, clk, rst, req.valid && req.ready |=> v[0], "request lost")
  `CSA_ASSERT(a_last_holds, clk, rst, v[NS-1] && !adv[NS-1] |=> v[NS-1], "stage lost item")

endmodule

@@ tb/sv/tb_checked_signed_alu.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_checked_signed_alu
// drives random and corner-case requests through the checked alu, predicts
// each result and error flag, and compares them in order under random stalls
// ----------------------------------------------------------------------------
module tb_checked_signed_alu;

  localparam int W = csa_pkg::W;

  typedef struct packed {
    logic [2:0]   cmd;
    logic [W-1:0] a;
    logic [W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [W-1:0] value;
    logic         err;
  } alu_rsp_t;

  localparam int LATENCY   = W + 2;
  localparam int IDLE_LIMIT = 20000;
  localparam int HOLD_CYCLES = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;

  csa_req_if req ();
  csa_rsp_if rsp ();

  checked_signed_alu dut (
    .clk(clk),
    .rst(rst),
    .req(req.sink),
    .rsp(rsp.source)
  );

  alu_req_t pending_reqs[$];
  alu_rsp_t expected_rsps[$];
  int       fail_count = 0;
  int       src_idle_pct = 0;
  int       snk_idle_pct = 0;
  bit       hold_off = 1'b0;
  bit       hold_go = 1'b0;
  bit       hold_done = 1'b0;
  bit       stim_done = 1'b0;
  int       quiet_cycles = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  // exact checked arithmetic on 33/66-bit values
  function automatic alu_rsp_t alu_predict(alu_req_t r);
    alu_rsp_t     o;
    logic signed [W:0]     s;
    logic signed [2*W+1:0] p;
    logic signed [W-1:0]   sa;
    logic signed [W-1:0]   sb;
    sa = r.a;
    sb = r.b;
    o.err = 1'b0;
    o.value = '0;
    case (r.cmd) inside
      csa_pkg::OP_ADD: begin
        s = $signed({sa[W-1], sa}) + $signed({sb[W-1], sb});
        o.value = s[W-1:0];
        o.err = s[W] != s[W-1];
      end
      csa_pkg::OP_SUB: begin
        s = $signed({sa[W-1], sa}) - $signed({sb[W-1], sb});
        o.value = s[W-1:0];
        o.err = s[W] != s[W-1];
      end
      csa_pkg::OP_MUL: begin
        p = $signed({{(W+2){sa[W-1]}}, sa}) * $signed({{(W+2){sb[W-1]}}, sb});
        o.value = p[W-1:0];
        o.err = p != $signed({{(W+2){p[W-1]}}, p[W-1:0]});
      end
      csa_pkg::OP_DIV, csa_pkg::OP_REM: begin
        if (r.b == '0 || (r.a == csa_pkg::SMIN && r.b == '1)) begin
          o.err = 1'b1;
        end else if (r.cmd == csa_pkg::OP_DIV) begin
          o.value = sa / sb;
        end else begin
          o.value = sa % sb;
        end
      end
      default: o.err = 1'b1;
    endcase
    if (o.err) o.value = '1;
    return o;
  endfunction

  function automatic logic [W-1:0] rand_operand();
    case ($urandom_range(0, 7))
      0: return csa_pkg::SMIN;
      1: return csa_pkg::SMAX;
      2: return '1;
      3: return '0;
      4: return W'($signed($urandom_range(0, 40)) - 20);
      5: return {{(W/2){1'b0}}, (W/2)'($urandom)} ^ ({W{$urandom_range(0, 1) == 1}});
      default: return $urandom;
    endcase
  endfunction

  task automatic push_req(logic [2:0] c, logic [W-1:0] a, logic [W-1:0] b);
    alu_req_t r;
    r.cmd = c;
    r.a = a;
    r.b = b;
    pending_reqs.push_back(r);
  endtask

  task automatic push_random(int n);
    logic [2:0] c;
    for (int i = 0; i < n; i++) begin
      c = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                       : 3'($urandom_range(csa_pkg::OP_ADD, csa_pkg::OP_REM));
      push_req(c, rand_operand(), rand_operand());
    end
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || req.valid || expected_rsps.size() != 0)
      @(posedge clk);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else if (!req.valid || req.ready) begin
      if (req.valid) expected_rsps.push_back(alu_predict({req.cmd, req.operand_a,
                                                          req.operand_b}));
      if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
        alu_req_t r;
        r = pending_reqs.pop_front();
        req.valid <= 1'b1;
        req.cmd <= r.cmd;
        req.operand_a <= r.a;
        req.operand_b <= r.b;
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  // monitor and receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_rsps.size() == 0) begin
          $error("unexpected result %h err %b", rsp.result, rsp.overflow_error);
          fail_count++;
        end else begin
          alu_rsp_t e;
          e = expected_rsps.pop_front();
          if (rsp.result !== e.value) begin
            $error("result: expected %h actual %h", e.value, rsp.result);
            fail_count++;
          end
          if (rsp.overflow_error !== e.err) begin
            $error("overflow_error: expected %b actual %b", e.err, rsp.overflow_error);
            fail_count++;
          end
        end
      end
      rsp.ready <= !hold_off && ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  // long receiver hold-off, counted here
  initial begin
    wait (hold_go);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off = 1'b0;
    hold_done = 1'b1;
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready) || stim_done) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    req.valid = 1'b0;
    req.cmd = csa_pkg::OP_ADD;
    req.operand_a = '0;
    req.operand_b = '0;
    rsp.ready = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // corner cases
    push_req(csa_pkg::OP_ADD, csa_pkg::SMAX, 1);
    push_req(csa_pkg::OP_ADD, csa_pkg::SMIN, '1);
    push_req(csa_pkg::OP_ADD, csa_pkg::SMAX, csa_pkg::SMIN);
    push_req(csa_pkg::OP_SUB, csa_pkg::SMIN, 1);
    push_req(csa_pkg::OP_SUB, csa_pkg::SMAX, '1);
    push_req(csa_pkg::OP_SUB, '0, csa_pkg::SMIN);
    push_req(csa_pkg::OP_MUL, csa_pkg::SMIN, 1);
    push_req(csa_pkg::OP_MUL, csa_pkg::SMIN, '1);
    push_req(csa_pkg::OP_MUL, 32'h0001_0000, 32'h0000_8000);
    push_req(csa_pkg::OP_MUL, 32'hffff_0000, 32'h0000_8000);
    push_req(csa_pkg::OP_MUL, csa_pkg::SMAX, csa_pkg::SMAX);
    push_req(csa_pkg::OP_MUL, '0, csa_pkg::SMIN);
    push_req(csa_pkg::OP_DIV, 7, '0);
    push_req(csa_pkg::OP_REM, 7, '0);
    push_req(csa_pkg::OP_DIV, csa_pkg::SMIN, '1);
    push_req(csa_pkg::OP_REM, csa_pkg::SMIN, '1);
    push_req(csa_pkg::OP_DIV, -32'sd7, 2);
    push_req(csa_pkg::OP_REM, -32'sd7, 2);
    push_req(csa_pkg::OP_REM, 7, -32'sd2);
    push_req(csa_pkg::OP_DIV, csa_pkg::SMIN, 1);
    push_req(csa_pkg::OP_DIV, csa_pkg::SMAX, csa_pkg::SMIN);
    // unused operation codes
    push_req(3'd5, 1, 1);
    push_req(3'd6, '1, '1);
    push_req(3'd7, csa_pkg::SMIN, csa_pkg::SMAX);

    src_idle_pct = 31;
    snk_idle_pct = 74;
    push_random(400);
    wait_drained();

    // long receiver hold-off so the pipeline fills and backs up
    src_idle_pct = 0;
    push_random(120);
    hold_go = 1'b1;
    wait (hold_done);
    wait_drained();

    src_idle_pct = 74;
    snk_idle_pct = 31;
    push_random(350);
    wait_drained();

    src_idle_pct = 0;
    snk_idle_pct = 0;
    push_random(350);
    wait_drained();

    for (int i = 0; i < 4 * LATENCY; i++) @(posedge clk);
    stim_done = 1'b1;
    if (fail_count == 0 && expected_rsps.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

@@ checked_signed_alu.f @@
+incdir+design
design/csa_pkg.sv
design/csa_req_if.sv
design/csa_rsp_if.sv
design/csa_stage.sv
design/checked_signed_alu.sv
tb/sv/tb_checked_signed_alu.sv
